FILE: rtl/ppsn_pkg.sv
// ----------------------------------------------------------------------------
// Partitioned point sort package
// Shared types and constants of the sort cell chain and the scaling divider.
// ----------------------------------------------------------------------------
package ppsn_pkg;

    localparam int MAX_POINTS = 64;
    localparam int FRAC_BITS  = 16;
    localparam int CNT_W      = $clog2(MAX_POINTS + 1);
    localparam int DIV_W      = 32 + FRAC_BITS;
    localparam int DCNT_W     = $clog2(DIV_W + 1);

    typedef struct packed {
        logic signed [31:0] x_coord;
        logic signed [31:0] y_coord;
        logic               last_point;
    } in_beat_t;

    typedef struct packed {
        logic signed [31:0] x_scaled;
        logic signed [31:0] y_scaled;
        logic               end_of_set;
        logic               zero_divisor;
        logic               points_dropped;
    } out_beat_t;

    typedef struct packed {
        logic        valid;
        logic [31:0] x;
        logic [31:0] y;
    } pt_t;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_POP,
        ST_DIVX,
        ST_DIVY,
        ST_EMIT
    } state_t;

    // True if point a must be emitted strictly after point b.
    function automatic logic goes_after(input logic [31:0] xa, input logic [31:0] ya,
                                        input logic [31:0] xb, input logic [31:0] yb);
        logic nega;
        logic negb;
        nega = ya[31];
        negb = yb[31];
        if (nega != negb)
            return nega;
        if (nega)
            return $signed(xa) < $signed(xb);
        return $signed(xa) > $signed(xb);
    endfunction

endpackage

FILE: rtl/ppsn_cell.sv
// ----------------------------------------------------------------------------
// Sort cell
// Holds one point; on insert keeps, replaces or passes points to the right
// neighbor so the chain stays ordered; on shift takes the right neighbor.
// ----------------------------------------------------------------------------
module ppsn_cell (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              insert,
    input  logic              shift,
    input  ppsn_pkg::pt_t     new_pt,
    input  ppsn_pkg::pt_t     left_pt,
    input  logic              left_take,
    input  ppsn_pkg::pt_t     right_pt,
    output ppsn_pkg::pt_t     cur_pt,
    output logic              take
);

    logic          valid_reg;
    logic          valid_next;
    logic [31:0]   x_reg;
    logic [31:0]   y_reg;
    logic [31:0]   x_next;
    logic [31:0]   y_next;

    // The new point belongs here once it must go before the held point.
    assign take = left_take || !valid_reg ||
                  ppsn_pkg::goes_after(x_reg, y_reg, new_pt.x, new_pt.y);

    assign cur_pt = '{valid: valid_reg, x: x_reg, y: y_reg};

    // Next contents of the cell.
    always_comb
    begin
        valid_next = valid_reg;
        x_next     = x_reg;
        y_next     = y_reg;
        if (shift)
        begin
            valid_next = right_pt.valid;
            x_next     = right_pt.x;
            y_next     = right_pt.y;
        end
        else if (insert && left_take)
        begin
            valid_next = left_pt.valid;
            x_next     = left_pt.x;
            y_next     = left_pt.y;
        end
        else if (insert && take)
        begin
            valid_next = 1'b1;
            x_next     = new_pt.x;
            y_next     = new_pt.y;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        x_reg <= x_next;
        y_reg <= y_next;
    end

endmodule

FILE: rtl/ppsn_div.sv
// ----------------------------------------------------------------------------
// Scaling divider
// Restoring divider, one quotient bit a cycle: (v << FRAC_BITS) / d with
// truncation toward zero and saturation to the signed 32-bit range.
// ----------------------------------------------------------------------------
module ppsn_div (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                go,
    input  logic signed [31:0]  num,
    input  logic [30:0]         den,
    output logic                done,
    output logic signed [31:0]  quo
);

    localparam int W = ppsn_pkg::DIV_W;

    logic                          busy_reg;
    logic [ppsn_pkg::DCNT_W-1:0]   cnt_reg;
    logic [W-1:0]                  dvd_reg;
    logic [31:0]                   rem_reg;
    logic                          neg_reg;
    logic                          done_reg;
    logic [31:0]                   trial;
    logic [31:0]                   rem_sh;
    logic [31:0]                   mag;
    logic [W:0]                    sq;
    logic [31:0]                   absn;

    assign absn   = num[31] ? (~num + 32'd1) : num;
    assign rem_sh = {rem_reg[30:0], dvd_reg[W-1]};
    assign trial  = rem_sh - {1'b0, den};

    // Iterate one quotient bit per cycle.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (go)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= ppsn_pkg::DCNT_W'(W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == ppsn_pkg::DCNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (go)
        begin
            dvd_reg <= {absn, {ppsn_pkg::FRAC_BITS{1'b0}}};
            rem_reg <= '0;
            neg_reg <= num[31];
        end
        else if (busy_reg)
        begin
            if (rem_sh >= {1'b0, den})
            begin
                rem_reg <= trial;
                dvd_reg <= {dvd_reg[W-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= rem_sh;
                dvd_reg <= {dvd_reg[W-2:0], 1'b0};
            end
        end
    end

    // Apply sign and saturate.
    assign sq = neg_reg ? ((W+1)'(0) - {1'b0, dvd_reg}) : {1'b0, dvd_reg};
    always_comb
    begin
        mag = 32'h7FFF_FFFF;
        if (neg_reg)
            mag = (dvd_reg > W'(33'h8000_0000)) ? 32'h8000_0000 : sq[31:0];
        else if (dvd_reg <= W'(32'h7FFF_FFFF))
            mag = dvd_reg[31:0];
    end
    assign quo  = mag;
    assign done = done_reg;

endmodule

FILE: rtl/partitioned_point_sort_normalize_top.sv
// Timing: after the last point each result waits for the shared bit-serial divider,
// run for x then y, unless no stored x is positive and the divider is skipped.
// Throughput: one point per cycle while loading; no new points are accepted
// while results are being produced (busy).
// Reset: asynchronous active low; clears the chain valid bits, counters and state.
// The receiver cannot stall; each result shows for exactly one cycle with strobe.
// ----------------------------------------------------------------------------
// Partitioned point sort top level
// Insertion chain of sort cells, then one shared divider scales each point.
// ----------------------------------------------------------------------------
module partitioned_point_sort_normalize_top (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  ppsn_pkg::in_beat_t  in_beat,
    output logic                strobe,
    output ppsn_pkg::out_beat_t out_beat
);

    localparam int N = ppsn_pkg::MAX_POINTS;

    ppsn_pkg::state_t              state_reg, state_next;
    logic [ppsn_pkg::CNT_W-1:0]    count_reg, count_next;
    logic signed [31:0]            largest_reg, largest_next;
    logic                          ovf_reg, ovf_next;
    logic [31:0]                   hx_reg, hy_reg;
    logic signed [31:0]            xs_reg;
    logic                          strobe_reg;
    ppsn_pkg::out_beat_t           out_reg;
    logic                          accept;
    logic                          stored;
    logic                          insert;
    logic                          shift;
    logic                          go;
    logic signed [31:0]            num;
    logic                          done;
    logic signed [31:0]            quo;
    logic                          zero;
    ppsn_pkg::pt_t                 new_pt;
    ppsn_pkg::pt_t                 cur [N];
    logic                          tk  [N];

    assign accept = start && !busy;
    assign stored = accept && (count_reg < ppsn_pkg::CNT_W'(N));
    assign insert = stored;
    assign new_pt = '{valid: 1'b1, x: in_beat.x_coord, y: in_beat.y_coord};
    assign zero   = largest_reg <= 0;

    // Chain of sort cells.
    for (genvar i = 0; i < N; i++)
    begin : g_cell
        ppsn_pkg::pt_t lp;
        ppsn_pkg::pt_t rp;
        logic          lt;
        if (i == 0)
        begin : g_first
            assign lp = '0;
            assign lt = 1'b0;
        end
        else
        begin : g_mid
            assign lp = cur[i-1];
            assign lt = tk[i-1];
        end
        if (i == N - 1)
        begin : g_lastc
            assign rp = '0;
        end
        else
        begin : g_r
            assign rp = cur[i+1];
        end
        ppsn_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .insert   (insert),
            .shift    (shift),
            .new_pt   (new_pt),
            .left_pt  (lp),
            .left_take(lt),
            .right_pt (rp),
            .cur_pt   (cur[i]),
            .take     (tk[i])
        );
    end

    ppsn_div u_div (
        .clk  (clk),
        .rst_n(rst_n),
        .go   (go),
        .num  (num),
        .den  (largest_reg[30:0]),
        .done (done),
        .quo  (quo)
    );

    // Sequencer: load, pop head, divide x then y (skipped when no stored x is positive), emit.
    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        largest_next = largest_reg;
        ovf_next     = ovf_reg;
        shift        = 1'b0;
        go           = 1'b0;
        num          = $signed(hx_reg);
        unique case (state_reg)
            ppsn_pkg::ST_LOAD:
            begin
                if (accept)
                begin
                    if (stored)
                    begin
                        count_next = count_reg + 1'b1;
                        if (in_beat.x_coord > largest_reg)
                            largest_next = in_beat.x_coord;
                    end
                    else
                        ovf_next = 1'b1;
                    if (in_beat.last_point)
                        state_next = ppsn_pkg::ST_POP;
                end
            end
            ppsn_pkg::ST_POP:
            begin
                shift = 1'b1;
                if (zero)
                    state_next = ppsn_pkg::ST_EMIT;
                else
                begin
                    go         = 1'b1;
                    num        = $signed(cur[0].x);
                    state_next = ppsn_pkg::ST_DIVX;
                end
            end
            ppsn_pkg::ST_DIVX:
            begin
                if (done)
                begin
                    go         = 1'b1;
                    num        = $signed(hy_reg);
                    state_next = ppsn_pkg::ST_DIVY;
                end
            end
            ppsn_pkg::ST_DIVY:
            begin
                if (done)
                    state_next = ppsn_pkg::ST_EMIT;
            end
            ppsn_pkg::ST_EMIT:
            begin
                if (cur[0].valid)
                    state_next = ppsn_pkg::ST_POP;
                else
                begin
                    state_next   = ppsn_pkg::ST_LOAD;
                    count_next   = '0;
                    largest_next = '0;
                    ovf_next     = 1'b0;
                end
            end
            default: state_next = ppsn_pkg::ST_LOAD;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ppsn_pkg::ST_LOAD;
            count_reg   <= '0;
            largest_reg <= '0;
            ovf_reg     <= 1'b0;
            strobe_reg  <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            largest_reg <= largest_next;
            ovf_reg     <= ovf_next;
            strobe_reg  <= (state_reg == ppsn_pkg::ST_EMIT);
        end
    end

    // Head point capture and result beat register.
    always_ff @(posedge clk)
    begin
        if (state_reg == ppsn_pkg::ST_POP)
        begin
            hx_reg <= cur[0].x;
            hy_reg <= cur[0].y;
        end
        if (state_reg == ppsn_pkg::ST_DIVX && done)
            xs_reg <= quo;
        if (state_reg == ppsn_pkg::ST_EMIT)
        begin
            out_reg.x_scaled       <= zero ? 32'sd0 : xs_reg;
            out_reg.y_scaled       <= zero ? 32'sd0 : quo;
            out_reg.end_of_set     <= !cur[0].valid;
            out_reg.zero_divisor   <= zero;
            out_reg.points_dropped <= ovf_reg;
        end
    end

    // The y quotient holds after the divider finishes, so EMIT can use it.
    assign busy     = (state_reg != ppsn_pkg::ST_LOAD);
    assign strobe   = strobe_reg;
    assign out_beat = out_reg;

    a_no_shift_in_load: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ppsn_pkg::ST_LOAD) |-> !shift)
        else $error("shift while loading");
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= ppsn_pkg::CNT_W'(N))
        else $error("count beyond capacity");
    a_strobe_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
        strobe |-> $past(state_reg == ppsn_pkg::ST_EMIT))
        else $error("strobe without emit");

endmodule
